// ----- src/cfdd_pkg.sv -----
// shared types, codes and constants of the download deframer
package cfdd_pkg;

  localparam int unsigned MaxData = 512;
  localparam int unsigned LenW = ($clog2(MaxData + 1) > 9) ? $clog2(MaxData + 1) : 9;

  localparam logic [7:0] SyncFirst  = 8'hA5;
  localparam logic [7:0] SyncSecond = 8'h5A;

  localparam logic [2:0] CmdNone  = 3'd0;
  localparam logic [2:0] CmdBegin = 3'd1;
  localparam logic [2:0] CmdData  = 3'd2;
  localparam logic [2:0] CmdEnd   = 3'd3;
  localparam logic [2:0] CmdAbort = 3'd4;

  localparam logic [LenW-1:0] BeginLen = LenW'(16);
  localparam logic [LenW-1:0] EndLen   = LenW'(4);
  localparam logic [LenW-1:0] MaxLen   = LenW'(MaxData);

  localparam logic [1:0] RplNone = 2'd0;
  localparam logic [1:0] RplAck  = 2'd1;
  localparam logic [1:0] RplNak  = 2'd2;
  localparam logic [1:0] RplBeat = 2'd3;

  localparam logic [2:0] StNone    = 3'd0;
  localparam logic [2:0] StOk      = 3'd1;
  localparam logic [2:0] StTimeout = 3'd2;
  localparam logic [2:0] StBad     = 3'd3;
  localparam logic [2:0] StSum     = 3'd4;

  localparam logic [2:0] EvNone    = 3'd0;
  localparam logic [2:0] EvBegun   = 3'd1;
  localparam logic [2:0] EvData    = 3'd2;
  localparam logic [2:0] EvDone    = 3'd3;
  localparam logic [2:0] EvAbort   = 3'd4;
  localparam logic [2:0] EvFail    = 3'd5;
  localparam logic [2:0] EvBeginTo = 3'd6;

  localparam logic [1:0] RegByteTo   = 2'd0;
  localparam logic [1:0] RegBeginTo  = 2'd1;
  localparam logic [1:0] RegHbPeriod = 2'd2;

  localparam logic [15:0] ByteToReset   = 16'd1000;
  localparam logic [23:0] BeginToReset  = 24'd600000;
  localparam logic [15:0] HbPeriodReset = 16'd500;

  typedef enum logic [2:0] {
    PhHunt,
    PhSync2,
    PhCmd,
    PhLenLo,
    PhLenHi,
    PhPayload,
    PhSum
  } ph_e;

  typedef struct packed {
    logic [15:0] byte_to;
    logic [23:0] begin_to;
    logic [15:0] hb_period;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  reply_code;
    logic        payload_valid;
    logic [1:0]  payload_kind;
    logic [8:0]  payload_index;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [2:0]  session_event;
    logic [31:0] bytes_written;
  } res_t;

endpackage

// ----- src/cfdd_cfg_regs.sv -----
// configuration register file of the download deframer
module cfdd_cfg_regs
  import cfdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        RegByteTo:   cfg_d.byte_to   = cfg_wdata_i[15:0];
        RegBeginTo:  cfg_d.begin_to  = cfg_wdata_i;
        RegHbPeriod: cfg_d.hb_period = cfg_wdata_i[15:0];
        default:     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.byte_to   <= ByteToReset;
      cfg_q.begin_to  <= BeginToReset;
      cfg_q.hb_period <= HbPeriodReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/cfdd_engine.sv -----
// deframer, session and timer state with the per-word update logic
module cfdd_engine
  import cfdd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       proc_i,
  input  logic       kind_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output res_t       res_o
);

  logic            sess_q, sess_d;
  ph_e             ph_q, ph_d;
  logic [2:0]      cmd_q, cmd_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic [15:0]     idle_q, idle_d;
  logic [23:0]     bt_q, bt_d;
  logic [15:0]     hb_q, hb_d;
  logic            hben_q, hben_d;
  logic [31:0]     decl_q, decl_d;
  logic [31:0]     wcnt_q, wcnt_d;
  res_t            res;

  always_comb begin
    logic [15:0]     idle_inc;
    logic [23:0]     bt_inc;
    logic [15:0]     hb_inc;
    logic [15:0]     len16;
    logic [LenW-1:0] pos_inc;
    logic [32:0]     wsum;
    logic            fin;
    logic [2:0]      fin_st;

    sess_d = sess_q;
    ph_d   = ph_q;
    cmd_d  = cmd_q;
    len_d  = len_q;
    pos_d  = pos_q;
    sum_d  = sum_q;
    idle_d = idle_q;
    bt_d   = bt_q;
    hb_d   = hb_q;
    hben_d = hben_q;
    decl_d = decl_q;
    wcnt_d = wcnt_q;
    res    = '0;
    fin    = 1'b0;
    fin_st = StNone;

    idle_inc = (idle_q == 16'hFFFF) ? idle_q : idle_q + 16'd1;
    bt_inc   = (bt_q == 24'hFFFFFF) ? bt_q : bt_q + 24'd1;
    hb_inc   = (hb_q == 16'hFFFF) ? hb_q : hb_q + 16'd1;
    len16    = {rx_byte_i, len_q[7:0]};
    pos_inc  = pos_q + LenW'(1);
    wsum     = {1'b0, wcnt_q} + 33'(len_q);

    if (proc_i) begin
      if (kind_i) begin
        if (!sess_q && bt_inc >= cfg_i.begin_to) begin
          res.session_event = EvBeginTo;
          sess_d = 1'b0;
          ph_d   = PhHunt;
          idle_d = '0;
          bt_d   = '0;
          hb_d   = '0;
          hben_d = 1'b1;
        end else begin
          if (!sess_q) begin
            bt_d = bt_inc;
          end
          idle_d = idle_inc;
          if (idle_inc >= cfg_i.byte_to) begin
            idle_d = '0;
            ph_d   = PhHunt;
            res.frame_status = StTimeout;
            if (sess_q) begin
              res.reply_code    = RplNak;
              res.session_event = EvFail;
              sess_d = 1'b0;
              bt_d   = '0;
              hb_d   = '0;
              hben_d = 1'b1;
            end
          end
          if (!sess_q && hben_q) begin
            hb_d = hb_inc;
            if (hb_inc >= cfg_i.hb_period) begin
              hb_d = '0;
              res.reply_code = RplBeat;
            end
          end
        end
      end else begin
        idle_d = '0;
        case (ph_q)
          PhSync2: begin
            if (rx_byte_i == SyncSecond) begin
              ph_d = PhCmd;
            end else if (rx_byte_i != SyncFirst) begin
              ph_d = PhHunt;
            end
          end
          PhCmd: begin
            sum_d = rx_byte_i;
            pos_d = '0;
            cmd_d = rx_byte_i[2:0];
            if (rx_byte_i == {5'd0, CmdBegin}) begin
              len_d = BeginLen;
              ph_d  = PhPayload;
              if (!sess_q) begin
                decl_d = '0;
              end
            end else if (rx_byte_i == {5'd0, CmdData}) begin
              ph_d = PhLenLo;
            end else if (rx_byte_i == {5'd0, CmdEnd}) begin
              len_d = EndLen;
              ph_d  = PhPayload;
            end else if (rx_byte_i == {5'd0, CmdAbort}) begin
              len_d = '0;
              ph_d  = PhSum;
            end else begin
              cmd_d  = CmdNone;
              fin    = 1'b1;
              fin_st = StBad;
            end
          end
          PhLenLo: begin
            sum_d = sum_q + rx_byte_i;
            len_d = LenW'(rx_byte_i);
            ph_d  = PhLenHi;
          end
          PhLenHi: begin
            sum_d = sum_q + rx_byte_i;
            if (len16 == 16'd0 || 32'(len16) > 32'(MaxData)) begin
              len_d  = len16[LenW-1:0];
              fin    = 1'b1;
              fin_st = StBad;
            end else begin
              len_d = len16[LenW-1:0];
              ph_d  = PhPayload;
            end
          end
          PhPayload: begin
            res.payload_valid = 1'b1;
            res.payload_kind  = 2'(cmd_q - 3'd1);
            res.payload_index = pos_q[8:0];
            res.payload_byte  = rx_byte_i;
            sum_d = sum_q + rx_byte_i;
            if (cmd_q == CmdBegin && !sess_q && pos_q >= LenW'(12) && pos_q < LenW'(16)) begin
              decl_d[{pos_q[1:0], 3'b000} +: 8] = decl_q[{pos_q[1:0], 3'b000} +: 8] | rx_byte_i;
            end
            pos_d = pos_inc;
            if (pos_inc >= len_q) begin
              ph_d = PhSum;
            end
          end
          PhSum: begin
            fin    = 1'b1;
            fin_st = (rx_byte_i == sum_q) ? StOk : StSum;
          end
          default: begin
            ph_d = (rx_byte_i == SyncFirst) ? PhSync2 : PhHunt;
          end
        endcase
      end

      if (fin) begin
        res.frame_status = fin_st;
        ph_d = PhHunt;
        if (!sess_q) begin
          hben_d = 1'b0;
          if (fin_st == StOk && cmd_d == CmdBegin) begin
            sess_d = 1'b1;
            wcnt_d = '0;
            res.reply_code    = RplAck;
            res.session_event = EvBegun;
          end else begin
            res.reply_code = RplNak;
          end
        end else if (fin_st != StOk) begin
          res.reply_code = RplNak;
        end else begin
          case (cmd_d)
            CmdData: begin
              wcnt_d = wsum[32] ? '1 : wsum[31:0];
              res.reply_code    = RplAck;
              res.session_event = EvData;
            end
            CmdEnd, CmdAbort: begin
              if (cmd_d == CmdAbort) begin
                res.reply_code    = RplAck;
                res.session_event = EvAbort;
              end else if (wcnt_q == decl_q) begin
                res.reply_code    = RplAck;
                res.session_event = EvDone;
              end else begin
                res.reply_code    = RplNak;
                res.session_event = EvFail;
              end
              sess_d = 1'b0;
              idle_d = '0;
              bt_d   = '0;
              hb_d   = '0;
              hben_d = 1'b1;
            end
            default: begin
              res.reply_code = RplNak;
            end
          endcase
        end
      end
    end
    res.bytes_written = wcnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sess_q <= 1'b0;
      ph_q   <= PhHunt;
      cmd_q  <= '0;
      len_q  <= '0;
      pos_q  <= '0;
      sum_q  <= '0;
      idle_q <= '0;
      bt_q   <= '0;
      hb_q   <= '0;
      hben_q <= 1'b1;
      decl_q <= '0;
      wcnt_q <= '0;
    end else begin
      sess_q <= sess_d;
      ph_q   <= ph_d;
      cmd_q  <= cmd_d;
      len_q  <= len_d;
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      idle_q <= idle_d;
      bt_q   <= bt_d;
      hb_q   <= hb_d;
      hben_q <= hben_d;
      decl_q <= decl_d;
      wcnt_q <= wcnt_d;
    end
  end

  assign res_o = res;

  a_tick_no_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && kind_i |-> !res.payload_valid)
    else $error("payload word produced on a tick");

  a_begun_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && res.session_event == EvBegun |=> sess_q)
    else $error("begun event without session start");

  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ph_q == PhPayload |-> pos_q < len_q && len_q <= MaxLen)
    else $error("payload position outside frame length");

  a_heartbeat_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_i && res.reply_code == RplBeat |-> !sess_q && hben_q)
    else $error("heartbeat outside idle wait");

endmodule

// ----- src/checksummed_file_download_deframer.sv -----
// top level of the checksummed file download deframer
//
//  port group      dir  content
//  s_axis_*        in   tdata: rx_byte[7:0]; tuser: kind[0]
//  m_axis_*        out  tdata: reply_code, payload_index, payload_byte,
//                       frame_status, session_event, bytes_written
//                       tuser: payload_valid, payload_kind
//  cfg_*           in   write enable, register index, write data
//
// one word per cycle sustained while m_axis_tready is high; a word is held in the input register,
// where the deframer state is updated, and its result sits in the output register
// reset returns to hunting for sync, waiting for begin, config at defaults
// a stalled output blocks the input register only; one more word is still taken
module checksummed_file_download_deframer
  import cfdd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
  input  logic        s_axis_tuser,   // kind[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // reply_code[1:0], payload_index[10:2],
                                      // payload_byte[18:11], frame_status[21:19],
                                      // session_event[24:22], bytes_written[56:25]
  output logic [2:0]  m_axis_tuser,   // payload_valid[0], payload_kind[2:1]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [23:0] cfg_wdata_i
);

  cfg_t       cfg;
  res_t       res;
  res_t       out_q;
  logic       out_vld_q;
  logic       in_vld_q;
  logic       in_kind_q;
  logic [7:0] in_byte_q;
  logic       adv;
  logic       s_fire;

  assign adv           = !out_vld_q || m_axis_tready;
  assign s_axis_tready = !in_vld_q || adv;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  cfdd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  cfdd_engine u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .proc_i    (in_vld_q && adv),
    .kind_i    (in_kind_q),
    .rx_byte_i (in_byte_q),
    .cfg_i     (cfg),
    .res_o     (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_fire) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_kind_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
    if (adv && in_vld_q) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = {out_q.payload_kind, out_q.payload_valid};
  assign m_axis_tdata  = {7'd0, out_q.bytes_written, out_q.session_event,
                          out_q.frame_status, out_q.payload_byte,
                          out_q.payload_index, out_q.reply_code};

endmodule

// ----- test/tb_checksummed_file_download_deframer.sv -----
// testbench for the download deframer: in-bench predictor, framed random traffic, stream checks
`timescale 1ns / 1ps

module tb_checksummed_file_download_deframer;
  import cfdd_pkg::*;

  typedef struct packed {
    logic       kind;
    logic [7:0] data;
  } word_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_we_i;
  logic [1:0]  cfg_addr_i;
  logic [23:0] cfg_wdata_i;

  checksummed_file_download_deframer u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  word_t       rx_items_q[$];
  res_t        deframer_out_q[$];
  logic [7:0]  frame_body[$];
  word_t       nxt_word;
  res_t        got_w;
  res_t        want_w;
  int unsigned words_made = 0;
  int unsigned err_cnt = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  logic        quiet;

  // predictor state
  logic        sess_open;
  ph_e         dphase;
  logic [2:0]  fcmd;
  logic [15:0] flen;
  logic [15:0] fpos;
  logic [7:0]  fsum;
  logic [15:0] idle_ticks;
  logic [23:0] wait_ticks;
  logic [15:0] beat_ticks;
  logic        beat_on;
  logic [31:0] size_decl;
  logic [31:0] size_done;
  logic [15:0] byte_to_ms;
  logic [23:0] begin_to_ms;
  logic [15:0] beat_ms;
  res_t        step_res;

  assign quiet = (cyc >= 800) && (cyc < 1600);

  function automatic void back_to_wait();
    sess_open  = 1'b0;
    dphase     = PhHunt;
    idle_ticks = '0;
    wait_ticks = '0;
    beat_ticks = '0;
    beat_on    = 1'b1;
  endfunction

  function automatic void close_frame(input logic [2:0] st);
    logic [32:0] sum33;
    step_res.frame_status = st;
    dphase = PhHunt;
    if (!sess_open) begin
      beat_on = 1'b0;
      if (st == StOk && fcmd == CmdBegin) begin
        sess_open = 1'b1;
        size_done = '0;
        step_res.reply_code    = RplAck;
        step_res.session_event = EvBegun;
      end else begin
        step_res.reply_code = RplNak;
      end
    end else if (st != StOk) begin
      step_res.reply_code = RplNak;
    end else begin
      case (fcmd)
        CmdData: begin
          sum33 = {1'b0, size_done} + {17'd0, flen};
          size_done = sum33[32] ? '1 : sum33[31:0];
          step_res.reply_code    = RplAck;
          step_res.session_event = EvData;
        end
        CmdEnd: begin
          if (size_done == size_decl) begin
            step_res.reply_code    = RplAck;
            step_res.session_event = EvDone;
          end else begin
            step_res.reply_code    = RplNak;
            step_res.session_event = EvFail;
          end
          back_to_wait();
        end
        CmdAbort: begin
          step_res.reply_code    = RplAck;
          step_res.session_event = EvAbort;
          back_to_wait();
        end
        default: step_res.reply_code = RplNak;
      endcase
    end
  endfunction

  function automatic void step_byte(input logic [7:0] b);
    idle_ticks = '0;
    case (dphase)
      PhSync2: begin
        if (b == SyncSecond) dphase = PhCmd;
        else if (b != SyncFirst) dphase = PhHunt;
      end
      PhCmd: begin
        fsum = b;
        fpos = '0;
        fcmd = b[2:0];
        if (b == 8'(CmdBegin)) begin
          flen   = 16'd16;
          dphase = PhPayload;
          if (!sess_open) size_decl = '0;
        end else if (b == 8'(CmdData)) begin
          dphase = PhLenLo;
        end else if (b == 8'(CmdEnd)) begin
          flen   = 16'd4;
          dphase = PhPayload;
        end else if (b == 8'(CmdAbort)) begin
          flen   = '0;
          dphase = PhSum;
        end else begin
          fcmd = CmdNone;
          close_frame(StBad);
        end
      end
      PhLenLo: begin
        fsum   = fsum + b;
        flen   = {8'h00, b};
        dphase = PhLenHi;
      end
      PhLenHi: begin
        fsum = fsum + b;
        flen = flen | {b, 8'h00};
        if (flen == 16'd0 || flen > MaxData) close_frame(StBad);
        else dphase = PhPayload;
      end
      PhPayload: begin
        step_res.payload_valid = 1'b1;
        step_res.payload_kind  = 2'(fcmd - 3'd1);
        step_res.payload_index = fpos[8:0];
        step_res.payload_byte  = b;
        fsum = fsum + b;
        if (fcmd == CmdBegin && !sess_open && fpos >= 16'd12 && fpos < 16'd16)
          size_decl = size_decl | (32'(b) << (8 * (fpos - 16'd12)));
        fpos = fpos + 16'd1;
        if (fpos >= flen) dphase = PhSum;
      end
      PhSum: close_frame((b == fsum) ? StOk : StSum);
      default: dphase = (b == SyncFirst) ? PhSync2 : PhHunt;
    endcase
  endfunction

  function automatic void step_tick();
    logic waiting;
    waiting = !sess_open;
    if (waiting) begin
      if (wait_ticks != 24'hFF_FFFF) wait_ticks = wait_ticks + 24'd1;
      if (wait_ticks >= begin_to_ms) begin
        step_res.session_event = EvBeginTo;
        back_to_wait();
        return;
      end
    end
    if (idle_ticks != 16'hFFFF) idle_ticks = idle_ticks + 16'd1;
    if (idle_ticks >= byte_to_ms) begin
      idle_ticks = '0;
      dphase = PhHunt;
      step_res.frame_status = StTimeout;
      if (!waiting) begin
        step_res.reply_code    = RplNak;
        step_res.session_event = EvFail;
        back_to_wait();
      end
    end
    if (waiting && beat_on) begin
      if (beat_ticks != 16'hFFFF) beat_ticks = beat_ticks + 16'd1;
      if (beat_ticks >= beat_ms) begin
        beat_ticks = '0;
        step_res.reply_code = RplBeat;
      end
    end
  endfunction

  function automatic res_t deframe_step(input logic kind, input logic [7:0] b);
    step_res = '0;
    if (kind) step_tick();
    else step_byte(b);
    step_res.bytes_written = size_done;
    return step_res;
  endfunction

  task automatic put_word(input logic kind, input logic [7:0] b);
    word_t w;
    w.kind = kind;
    w.data = b;
    rx_items_q.push_back(w);
    words_made++;
  endtask

  task automatic put_ticks(input int unsigned n);
    int unsigned k;
    for (k = 0; k < n; k++) put_word(1'b1, 8'($urandom));
  endtask

  // byte with an occasional stray tick ahead of it
  task automatic put_rx(input logic [7:0] b);
    if ($urandom_range(0, 29) == 0) put_word(1'b1, 8'($urandom));
    put_word(1'b0, b);
  endtask

  task automatic put_frame(input logic [7:0] cmd, input bit bad_sum);
    logic [7:0] s;
    int unsigned k;
    s = cmd;
    put_rx(SyncFirst);
    put_rx(SyncSecond);
    put_rx(cmd);
    for (k = 0; k < frame_body.size(); k++) begin
      s = s + frame_body[k];
      put_rx(frame_body[k]);
    end
    if (bad_sum) s = s ^ (8'd1 << $urandom_range(0, 7));
    put_rx(s);
  endtask

  task automatic put_bad_len();
    logic [15:0] v;
    v = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(MaxData + 1, 65535));
    put_rx(SyncFirst);
    put_rx(SyncSecond);
    put_rx(8'(CmdData));
    put_rx(v[7:0]);
    put_rx(v[15:8]);
  endtask

  function automatic int unsigned timeout_run();
    int unsigned n;
    n = (byte_to_ms == 16'd0) ? 1 : ((byte_to_ms > 16'd60) ? 60 : int'(byte_to_ms));
    return n + $urandom_range(0, 2);
  endfunction

  task automatic put_session(input bit force_big);
    int unsigned n_data, total, i, k, pick;
    int unsigned lens[4];
    logic [31:0] decl;
    n_data = force_big ? 1 + $urandom_range(0, 1) : $urandom_range(0, 4);
    total = 0;
    for (i = 0; i < n_data; i++) begin
      pick = $urandom_range(0, 99);
      if (force_big && i == 0) lens[i] = MaxData;
      else if (pick < 85) lens[i] = $urandom_range(1, 8);
      else if (pick < 98) lens[i] = $urandom_range(9, 48);
      else lens[i] = $urandom_range(200, 300);
      total += lens[i];
    end
    pick = $urandom_range(0, 9);
    decl = (pick == 0) ? $urandom : ((pick == 1) ? total + $urandom_range(1, 3) : total);
    frame_body.delete();
    for (k = 0; k < 12; k++) frame_body.push_back(8'($urandom));
    for (k = 0; k < 4; k++) frame_body.push_back(decl[8*k +: 8]);
    put_frame(8'(CmdBegin), $urandom_range(0, 11) == 0);
    if ($urandom_range(0, 9) == 0) put_frame(8'(CmdBegin), 1'b0);
    for (i = 0; i < n_data; i++) begin
      pick = $urandom_range(0, 29);
      if (pick == 0) put_ticks(timeout_run());
      else if (pick == 1) put_bad_len();
      frame_body.delete();
      frame_body.push_back(lens[i][7:0]);
      frame_body.push_back(lens[i][15:8]);
      for (k = 0; k < lens[i]; k++) frame_body.push_back(8'($urandom));
      put_frame(8'(CmdData), $urandom_range(0, 11) == 0);
    end
    pick = $urandom_range(0, 9);
    frame_body.delete();
    if (pick < 6) begin
      for (k = 0; k < 4; k++) frame_body.push_back(8'($urandom));
      put_frame(8'(CmdEnd), $urandom_range(0, 11) == 0);
    end else if (pick < 8) begin
      put_frame(8'(CmdAbort), $urandom_range(0, 11) == 0);
    end else if (pick == 8) begin
      put_ticks(timeout_run());
    end
  endtask

  task automatic put_noise();
    int unsigned pick, n, k;
    pick = $urandom_range(0, 4);
    case (pick)
      0: begin
        n = $urandom_range(1, 6);
        for (k = 0; k < n; k++) put_rx(8'($urandom));
      end
      1: put_ticks($urandom_range(1, 40));
      2: begin
        put_rx(SyncFirst);
        put_rx(SyncFirst);
        put_rx(SyncSecond);
        put_rx(8'($urandom_range(5, 255)));
      end
      3: put_bad_len();
      default: begin
        put_rx(SyncFirst);
        put_rx(SyncSecond);
        put_rx(8'($urandom_range(1, 4)));
        n = $urandom_range(0, 5);
        for (k = 0; k < n; k++) put_rx(8'($urandom));
      end
    endcase
  endtask

  task automatic fill_batch(input bit force_big);
    int unsigned target;
    target = words_made + 100;
    while (words_made < target) begin
      if (force_big) begin
        put_session(1'b1);
        force_big = 1'b0;
      end else if ($urandom_range(0, 9) < 7) begin
        put_session(1'b0);
      end else begin
        put_noise();
      end
      put_ticks($urandom_range(0, 3));
    end
  endtask

  // sampled mid-cycle so the driver and monitor updates of the edge are seen
  task automatic wait_drained();
    while (rx_items_q.size() != 0 || s_axis_tvalid || deframer_out_q.size() != 0)
      @(negedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [23:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    if (idx == RegByteTo) byte_to_ms = val[15:0];
    else if (idx == RegBeginTo) begin_to_ms = val;
    else if (idx == RegHbPeriod) beat_ms = val[15:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      err_cnt++;
      if (err_cnt <= 100)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        deframer_out_q.push_back(deframe_step(s_axis_tuser, s_axis_tdata));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (rx_items_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)) begin
          nxt_word = rx_items_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= nxt_word.data;
          s_axis_tuser  <= nxt_word.kind;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_w.reply_code    = m_axis_tdata[1:0];
        got_w.payload_index = m_axis_tdata[10:2];
        got_w.payload_byte  = m_axis_tdata[18:11];
        got_w.frame_status  = m_axis_tdata[21:19];
        got_w.session_event = m_axis_tdata[24:22];
        got_w.bytes_written = m_axis_tdata[56:25];
        got_w.payload_valid = m_axis_tuser[0];
        got_w.payload_kind  = m_axis_tuser[2:1];
        if (deframer_out_q.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 100)
            $display("%0t: word with nothing expected, expected none, got %h / %h",
                     $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want_w = deframer_out_q.pop_front();
          check_field("reply_code", 32'(want_w.reply_code), 32'(got_w.reply_code));
          check_field("payload_valid", 32'(want_w.payload_valid), 32'(got_w.payload_valid));
          check_field("payload_kind", 32'(want_w.payload_kind), 32'(got_w.payload_kind));
          check_field("payload_index", 32'(want_w.payload_index), 32'(got_w.payload_index));
          check_field("payload_byte", 32'(want_w.payload_byte), 32'(got_w.payload_byte));
          check_field("frame_status", 32'(want_w.frame_status), 32'(got_w.frame_status));
          check_field("session_event", 32'(want_w.session_event), 32'(got_w.session_event));
          check_field("bytes_written", want_w.bytes_written, got_w.bytes_written);
        end
      end
      if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && cyc >= 250 && rx_items_q.size() > 20) begin
        hold_left     <= 60;
        hold_done     <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(0, 99) >= 10);
      end
    end
  end

  initial begin
    #400_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned phase_no;
    logic [23:0] bt, gt, hp;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    byte_to_ms    = ByteToReset;
    begin_to_ms   = BeginToReset;
    beat_ms       = HbPeriodReset;
    fcmd          = CmdNone;
    flen          = '0;
    fpos          = '0;
    fsum          = '0;
    size_decl     = '0;
    size_done     = '0;
    back_to_wait();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // noise, ticks, sliding resync, bad command, wrong command while waiting, bad lengths
    put_word(1'b0, 8'h00);
    put_word(1'b0, 8'hFF);
    put_word(1'b1, 8'hFF);
    put_word(1'b1, 8'h00);
    put_word(1'b0, SyncFirst);
    put_word(1'b0, SyncFirst);
    put_word(1'b0, SyncSecond);
    put_word(1'b0, 8'hFF);
    put_word(1'b0, SyncFirst);
    put_word(1'b0, SyncSecond);
    put_word(1'b0, 8'(CmdAbort));
    put_word(1'b0, 8'(CmdAbort));
    put_word(1'b0, SyncFirst);
    put_word(1'b0, SyncSecond);
    put_word(1'b0, 8'(CmdData));
    put_word(1'b0, 8'h00);
    put_word(1'b0, 8'h00);
    put_word(1'b0, SyncFirst);
    put_word(1'b0, SyncSecond);
    put_word(1'b0, 8'(CmdData));
    put_word(1'b0, 8'h01);
    put_word(1'b0, 8'h02);
    fill_batch(1'b0);

    phase_no = 0;
    while (words_made < 1250) begin
      wait_drained();
      phase_no++;
      case (phase_no)
        1: begin
          bt = 24'd1;
          gt = 24'd1;
          hp = 24'd1;
        end
        2: begin
          bt = 24'h00_FFFF;
          gt = 24'hFF_FFFF;
          hp = 24'h00_FFFF;
        end
        3: begin
          bt = 24'd0;
          gt = 24'd0;
          hp = 24'd0;
        end
        default: begin
          bt = 24'($urandom_range(3, 30));
          gt = 24'($urandom_range(30, 600));
          hp = 24'($urandom_range(1, 20));
        end
      endcase
      cfg_write(RegByteTo, bt);
      cfg_write(RegBeginTo, gt);
      cfg_write(RegHbPeriod, hp);
      fill_batch(phase_no == 2);
    end
    wait_drained();
    if (err_cnt == 0 && deframer_out_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
